// File: hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and the UTF-8 encoder for the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF = 65535;
  localparam int unsigned COUNT_W           = 16;
  localparam int unsigned COUNT_MAX         = 65535;
  localparam int unsigned FIFO_DEPTH        = 4;
  localparam int unsigned FIFO_AW           = $clog2(FIFO_DEPTH);
  localparam int unsigned CP_W              = 21;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // One decoded step: up to four output bytes plus an optional terminator
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            term;
    logic            bad;
  } job_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
  } enc_t;

  typedef struct packed {
    logic full;
    logic avail;
  } fifo_stat_t;

  function automatic enc_t utf8_encode(input logic [CP_W-1:0] cp);
    enc_t e;
    e = '0;
    if (cp < CP_W'('h80)) begin
      e.nbytes   = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp < CP_W'('h800)) begin
      e.nbytes   = 3'd2;
      e.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      e.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
    end else if (cp < CP_W'('h10000)) begin
      e.nbytes   = 3'd3;
      e.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      e.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      e.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      e.nbytes   = 3'd4;
      e.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
      e.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      e.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      e.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// Input byte channel: one raw token byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// Output channel: one decoded byte or one terminator per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        end_mark;
  logic [15:0] out_count;
  logic        bad_end;

  modport source (output valid, output out_byte, output end_mark, output out_count,
                  output bad_end, input ready);
  modport sink   (input valid, input out_byte, input end_mark, input out_count,
                  input bad_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape parser: takes one token byte per cycle while the job queue is not full and queues the bytes it decodes.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire logic         clk,
  input  wire logic         rst,
  jsu_in_if.sink            in_ch,
  input  wire logic         q_full,
  output logic              push,
  output jsu_pkg::job_t     push_job
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX1   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_HEX2   = 3'd4,
    PH_COPY   = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  digit_index, digit_index_next;
  logic [1:0]  copy_left, copy_left_next;
  logic [15:0] first_unit, first_unit_next;
  logic [15:0] second_unit, second_unit_next;

  logic        acc;
  logic [7:0]  c;
  logic [3:0]  hv;
  logic [15:0] unit1, unit2;
  logic [CP_W-1:0] pair_cp;
  enc_t        enc1, enc2;
  job_t        job;

  function automatic logic [8:0] simple_escape(input logic [7:0] ch);
    logic [8:0] r;
    case (ch)
      8'h22:   r = {1'b1, 8'h22};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = '0;
    endcase
    return r;
  endfunction

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign c           = in_ch.data_byte;

  // Letters of either case land on low nibble + 9; no digit check
  assign hv = (c >= 8'h41) ? (c[3:0] + 4'd9) : c[3:0];

  assign unit1   = {first_unit[11:0], hv};
  assign unit2   = {second_unit[11:0], hv};
  // (first - D800) << 10 + second - DC00 + 10000; first is a high surrogate here
  assign pair_cp = {1'b0, first_unit[9:0], 10'b0} + CP_W'(unit2) + CP_W'('h2400);
  assign enc1    = utf8_encode(CP_W'(unit1));
  assign enc2    = utf8_encode(pair_cp);

  always_comb begin
    logic [8:0] se;
    se               = simple_escape(c);
    phase_next       = phase;
    digit_index_next = digit_index;
    copy_left_next   = copy_left;
    first_unit_next  = first_unit;
    second_unit_next = second_unit;
    job              = '0;

    case (phase)
      PH_ESC: begin
        if (se[8]) begin
          job.nbytes   = 3'd1;
          job.bytes[0] = se[7:0];
          phase_next   = PH_NORMAL;
        end else begin
          phase_next       = PH_HEX1;
          digit_index_next = 2'd0;
          first_unit_next  = '0;
        end
      end
      PH_HEX1: begin
        first_unit_next = unit1;
        if (digit_index == 2'd3) begin
          digit_index_next = 2'd0;
          if (unit1 >= 16'hD800 && unit1 <= 16'hDBFF) begin
            phase_next = PH_SKIP;
          end else begin
            job.bytes  = enc1.bytes;
            job.nbytes = enc1.nbytes;
            phase_next = PH_NORMAL;
          end
        end else begin
          digit_index_next = digit_index + 2'd1;
        end
      end
      PH_SKIP: begin
        if (digit_index == 2'd1) begin
          digit_index_next = 2'd0;
          second_unit_next = '0;
          phase_next       = PH_HEX2;
        end else begin
          digit_index_next = 2'd1;
        end
      end
      PH_HEX2: begin
        second_unit_next = unit2;
        if (digit_index == 2'd3) begin
          digit_index_next = 2'd0;
          job.bytes        = enc2.bytes;
          job.nbytes       = enc2.nbytes;
          phase_next       = PH_NORMAL;
        end else begin
          digit_index_next = digit_index + 2'd1;
        end
      end
      PH_COPY: begin
        job.nbytes     = 3'd1;
        job.bytes[0]   = c;
        copy_left_next = copy_left - 2'd1;
        if (copy_left == 2'd1) begin
          phase_next = PH_NORMAL;
        end
      end
      default: begin
        if (c == CH_BACKSLASH) begin
          phase_next = PH_ESC;
        end else if (c >= 8'h80) begin
          job.nbytes     = 3'd1;
          job.bytes[0]   = c;
          copy_left_next = (c >= 8'hF0) ? 2'd3 : (c >= 8'hE0) ? 2'd2 : 2'd1;
          phase_next     = PH_COPY;
        end else begin
          job.nbytes   = 3'd1;
          job.bytes[0] = c;
          phase_next   = PH_NORMAL;
        end
      end
    endcase

    if (in_ch.last_byte) begin
      job.term = 1'b1;
      job.bad  = (phase_next == PH_ESC) || (phase_next == PH_HEX1) ||
                 (phase_next == PH_SKIP) || (phase_next == PH_HEX2);
      phase_next       = PH_NORMAL;
      digit_index_next = '0;
      copy_left_next   = '0;
      first_unit_next  = '0;
      second_unit_next = '0;
    end
  end

  assign push     = acc && (job.nbytes != 3'd0 || job.term);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NORMAL;
      digit_index <= '0;
      copy_left   <= '0;
      first_unit  <= '0;
      second_unit <= '0;
    end else if (acc) begin
      phase       <= phase_next;
      digit_index <= digit_index_next;
      copy_left   <= copy_left_next;
      first_unit  <= first_unit_next;
      second_unit <= second_unit_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Short job queue between the parser and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire jsu_pkg::job_t push_job,
  input  wire logic          pop,
  output jsu_pkg::job_t      head,
  output jsu_pkg::fifo_stat_t stat
);
  import jsu_pkg::*;

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   cnt;

  assign head       = mem[rd_ptr];
  assign stat.full  = (cnt == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.avail = (cnt != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Byte emitter: plays out queued jobs one byte per cycle while the output is taken, then the terminator if any.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back #(
  parameter int unsigned MAX_TOKEN_LEN = jsu_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire jsu_pkg::job_t head,
  input  wire logic          avail,
  output logic               pop,
  jsu_out_if.source          out_ch
);
  import jsu_pkg::*;

  localparam int unsigned CAP = (MAX_TOKEN_LEN > COUNT_MAX) ? COUNT_MAX : MAX_TOKEN_LEN;
  localparam logic [COUNT_W-1:0] CAP_V = CAP[COUNT_W-1:0];

  logic               o_valid;
  logic [7:0]         o_byte;
  logic               o_end;
  logic [COUNT_W-1:0] o_count;
  logic               o_bad;

  logic [2:0]         idx;
  logic [COUNT_W-1:0] count;
  logic               load;
  logic               is_byte;
  logic               job_done;

  assign load     = avail && (!o_valid || out_ch.ready);
  assign is_byte  = idx < head.nbytes;
  assign job_done = is_byte ? ((idx + 3'd1 == head.nbytes) && !head.term) : 1'b1;
  assign pop      = load && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      idx     <= '0;
      count   <= '0;
    end else begin
      if (o_valid && out_ch.ready) begin
        o_valid <= 1'b0;
      end
      if (load) begin
        o_valid <= 1'b1;
        if (is_byte) begin
          if (count < CAP_V) begin
            count <= count + 1'b1;
          end
          idx <= job_done ? 3'd0 : idx + 3'd1;
        end else begin
          count <= '0;
          idx   <= '0;
        end
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      if (is_byte) begin
        o_byte  <= head.bytes[idx[1:0]];
        o_end   <= 1'b0;
        o_count <= '0;
        o_bad   <= 1'b0;
      end else begin
        o_byte  <= '0;
        o_end   <= 1'b1;
        o_count <= count;
        o_bad   <= head.bad;
      end
    end
  end

  assign out_ch.valid     = o_valid;
  assign out_ch.out_byte  = o_byte;
  assign out_ch.end_mark  = o_end;
  assign out_ch.out_count = o_count;
  assign out_ch.bad_end   = o_bad;

endmodule

`default_nettype wire

// File: hw/rtl/json_string_unescape_utf8.sv
// Path: an accepted byte's decoded job is registered in the job queue, and its results then in the output register.
// Throughput: one input byte per cycle while the 4-entry job queue has room; the
//   output register gives one result per cycle while the sink is ready, so a step
//   holds the emitter until all its results are out (up to 4 bytes plus the terminator).
// Reset: synchronous, active high; clears the parser state, queue and output valid.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string unescaper to UTF-8: parser front, job queue, byte emitter back.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int unsigned MAX_TOKEN_LEN = jsu_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  localparam int unsigned CAP = (MAX_TOKEN_LEN > COUNT_MAX) ? COUNT_MAX : MAX_TOKEN_LEN;

  logic       push;
  job_t       push_job;
  logic       pop;
  job_t       head;
  fifo_stat_t stat;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_full   (stat.full),
    .push     (push),
    .push_job (push_job)
  );

  jsu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  jsu_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .avail  (stat.avail),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !push) else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> stat.avail) else $error("job queue read while empty");

  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.end_mark) |-> (out_ch.out_count == '0 && !out_ch.bad_end))
    else $error("count or error flag set on a data byte");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.end_mark) |-> (32'(out_ch.out_count) <= CAP))
    else $error("byte count above cap");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid) else $error("output valid right after reset");

endmodule

`default_nettype wire
